FILE: src/accel_motion_detector_unit_defines.svh
// Assertion macros used by the motion detector top level.
`ifndef ACCEL_MOTION_DETECTOR_UNIT_DEFINES_SVH
`define ACCEL_MOTION_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, idle while reset is asserted.
`define AMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, idle while reset is asserted.
`define AMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/amd_pkg.sv
// Types and constants of the accelerometer motion detector.
`default_nettype none

package amd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int THRESH_W       = 16;
    localparam int FRAC_W         = 8;
    localparam int AVG_W          = 25;
    localparam int MAG_W          = 25;
    localparam int SUM_W          = 2 * MAG_W;
    localparam int DEV_SHIFT      = 16;
    localparam int DEV_W          = 34;
    localparam int NUM_AXES       = 3;
    localparam int AXIS_W         = 2;
    localparam int AVG_OLD_WEIGHT = 179;
    localparam int AVG_NEW_WEIGHT = 77;

    localparam logic [AXIS_W-1:0] AXIS_FIRST = '0;
    localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_W'(NUM_AXES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SQUARE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              update;
        logic              square;
        logic [AXIS_W-1:0] axis;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

`default_nettype wire

FILE: src/amd_in_if.sv
// Input channel: one three-axis sample beat with per-axis valid flags.
`default_nettype none

interface amd_in_if;
    import amd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] z_sample;
    logic                       x_valid;
    logic                       y_valid;
    logic                       z_valid;

    modport source (
        output valid, x_sample, y_sample, z_sample, x_valid, y_valid, z_valid,
        input  ready
    );

    modport sink (
        input  valid, x_sample, y_sample, z_sample, x_valid, y_valid, z_valid,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/amd_out_if.sv
// Output channel: walking flag and squared deviation per sample.
`default_nettype none

interface amd_out_if;
    import amd_pkg::*;

    logic             valid;
    logic             ready;
    logic             walking;
    logic [DEV_W-1:0] deviation_squared;

    modport source (
        output valid, walking, deviation_squared,
        input  ready
    );

    modport sink (
        input  valid, walking, deviation_squared,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/accel_motion_detector_unit.sv
// Top level of the accelerometer motion detector.
//
//  channel   | dir | handshake     | beat contents
//  ----------+-----+---------------+---------------------------------------------
//  i_in      | in  | valid/ready   | x/y/z sample (s16) and x/y/z valid flags
//  o_out     | out | valid/ready   | walking flag, deviation_squared (u34)
//  i_cfg_*   | in  | write enable  | motion_threshold (u16)
//
// After acceptance a sample goes through an average update, then three passes
// through the shared 25x25 squarer, then the final sum and compare.
// The input is ready again once the result sits in the output register, so a new
// sample is taken while the previous result waits; a full output register stalls
// the final step. Synchronous active-low reset clears averages, held samples,
// threshold and the seeded flag; the first sample after reset seeds the averages.
`default_nettype none

module accel_motion_detector_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    amd_in_if.sink                             i_in,
    amd_out_if.source                          o_out,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [amd_pkg::THRESH_W-1:0]  i_cfg_wr_data
);
    import amd_pkg::*;

`include "accel_motion_detector_unit_defines.svh"

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;
    logic    w_in_beat;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign w_in_beat   = i_in.valid && w_in_ready;

    amd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    amd_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_x_sample          (i_in.x_sample),
        .i_y_sample          (i_in.y_sample),
        .i_z_sample          (i_in.z_sample),
        .i_x_valid           (i_in.x_valid),
        .i_y_valid           (i_in.y_valid),
        .i_z_valid           (i_in.z_valid),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .o_out_valid         (w_out_valid),
        .i_out_ready         (o_out.ready),
        .o_walking           (o_out.walking),
        .o_deviation_squared (o_out.deviation_squared)
    );

    // an accepted beat always starts the average update next cycle
    `AMD_ASSERT_NEXT(a_beat_starts_update, i_clk, i_rst_n, w_in_beat, w_cmd.update, "accepted beat did not start an update")

    // no second beat while the current sample is still being worked
    `AMD_ASSERT_NEXT(a_no_ready_after_beat, i_clk, i_rst_n, w_in_beat, !w_in_ready, "input ready straight after a beat")

    // never overwrite a result that has not been taken
    `AMD_ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.finish, (!w_out_valid || o_out.ready), "result loaded over a pending beat")

endmodule

`default_nettype wire

FILE: src/amd_ctrl.sv
// Controller: sequences average update, per-axis squaring and result load.
`default_nettype none

module amd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire amd_pkg::t_status i_status,
    output amd_pkg::t_cmd       o_cmd
);
    import amd_pkg::*;

    t_state            r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= AXIS_FIRST;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_SQUARE;
                n_axis  = AXIS_FIRST;
            end
            ST_SQUARE: begin
                if (r_axis == AXIS_LAST) begin
                    n_state = ST_FINISH;
                end else begin
                    n_axis = r_axis + AXIS_W'(1);
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!i_status.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.axis   = r_axis;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = !i_status.out_full;
            end
            default: begin
                o_cmd.update = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/amd_datapath.sv
// Datapath: held samples, running averages, shared squarer and output register.
`default_nettype none

module amd_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire amd_pkg::t_cmd                  i_cmd,
    output amd_pkg::t_status                    o_status,
    input  wire logic signed [amd_pkg::SAMPLE_W-1:0] i_x_sample,
    input  wire logic signed [amd_pkg::SAMPLE_W-1:0] i_y_sample,
    input  wire logic signed [amd_pkg::SAMPLE_W-1:0] i_z_sample,
    input  wire logic                           i_x_valid,
    input  wire logic                           i_y_valid,
    input  wire logic                           i_z_valid,
    input  wire logic [amd_pkg::THRESH_W-1:0]   i_cfg_wr_data,
    input  wire logic                           i_cfg_wr_en,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_walking,
    output logic [amd_pkg::DEV_W-1:0]           o_deviation_squared
);
    import amd_pkg::*;

    localparam int ACC_W  = AVG_W + 9;
    localparam int DIFF_W = AVG_W + 1;
    localparam int THSQ_W = 2 * THRESH_W;

    logic signed [SAMPLE_W-1:0] r_held [NUM_AXES];
    logic signed [AVG_W-1:0]    r_avg  [NUM_AXES];
    logic                       r_seeded;
    logic [THRESH_W-1:0]        r_thresh;
    logic [THSQ_W-1:0]          r_th_sq;
    logic [SUM_W-1:0]           r_prod;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_out_valid;
    logic                       r_walking;
    logic [DEV_W-1:0]           r_dev;

    logic signed [SAMPLE_W-1:0] w_in_sample [NUM_AXES];
    logic                       w_in_valid  [NUM_AXES];
    logic signed [AVG_W-1:0]    w_avg_next  [NUM_AXES];
    logic signed [ACC_W-1:0]    w_acc       [NUM_AXES];
    logic signed [DIFF_W-1:0]   w_diff;
    logic [MAG_W-1:0]           w_mag;
    logic [SUM_W-1:0]           n_sum;

    assign w_in_sample[0] = i_x_sample;
    assign w_in_sample[1] = i_y_sample;
    assign w_in_sample[2] = i_z_sample;
    assign w_in_valid[0]  = i_x_valid;
    assign w_in_valid[1]  = i_y_valid;
    assign w_in_valid[2]  = i_z_valid;

    // avg' = floor((179*avg + 77*256*held) / 256); seeding loads held*256
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_acc[k] = ACC_W'(r_avg[k]) * ACC_W'(AVG_OLD_WEIGHT)
                     + ACC_W'(r_held[k]) * ACC_W'(AVG_NEW_WEIGHT * (2 ** FRAC_W));
            if (r_seeded) begin
                w_avg_next[k] = w_acc[k][FRAC_W +: AVG_W];
            end else begin
                w_avg_next[k] = AVG_W'(r_held[k]) <<< FRAC_W;
            end
        end
    end

    always_comb begin
        w_diff = DIFF_W'(r_avg[i_cmd.axis]) - (DIFF_W'(r_held[i_cmd.axis]) <<< FRAC_W);
        if (w_diff[DIFF_W-1]) begin
            w_mag = MAG_W'(-w_diff);
        end else begin
            w_mag = MAG_W'(w_diff);
        end
    end

    assign n_sum = r_sum + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded    <= 1'b0;
            r_thresh    <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_held[k] <= '0;
                r_avg[k]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    if (w_in_valid[k]) begin
                        r_held[k] <= w_in_sample[k];
                    end
                end
            end
            if (i_cmd.update) begin
                r_seeded <= 1'b1;
                for (int k = 0; k < NUM_AXES; k++) begin
                    r_avg[k] <= w_avg_next[k];
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_th_sq <= THSQ_W'(r_thresh) * THSQ_W'(r_thresh);
        if (i_cmd.update) begin
            r_prod <= '0;
            r_sum  <= '0;
        end else if (i_cmd.square) begin
            r_prod <= SUM_W'(w_mag) * SUM_W'(w_mag);
            r_sum  <= n_sum;
        end
        if (i_cmd.finish) begin
            r_walking <= (n_sum > SUM_W'({r_th_sq, DEV_SHIFT'(0)}));
            r_dev     <= n_sum[DEV_SHIFT +: DEV_W];
        end
    end

    assign o_status.out_full   = r_out_valid && !i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_walking           = r_walking;
    assign o_deviation_squared = r_dev;

endmodule

`default_nettype wire
